### rtl/core/tbce_pkg.sv
// ----------------------------------------------------------------------------
// tbce_pkg
// Shared constants, codes and types of the text buffer cursor editor.
// ----------------------------------------------------------------------------
package tbce_pkg;

    localparam int TEXT_DEPTH = 1024;
    localparam int CLIP_DEPTH = 512;

    localparam int CMD_W   = 4;
    localparam int CHAR_W  = 8;
    localparam int AMT_W   = 16;
    localparam int IDX_W   = 10;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = $clog2(TEXT_DEPTH + 1);
    localparam int CLEN_W  = $clog2(CLIP_DEPTH + 1);
    localparam int TEXT_AW = $clog2(TEXT_DEPTH);
    localparam int CLIP_AW = $clog2(CLIP_DEPTH);
    localparam int ADDR_W  = (TEXT_AW > CLIP_AW) ? TEXT_AW : CLIP_AW;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 4'd0,
        CMD_START    = 4'd1,
        CMD_END      = 4'd2,
        CMD_FORWARD  = 4'd3,
        CMD_BACKWARD = 4'd4,
        CMD_DELETE   = 4'd5,
        CMD_COPY     = 4'd6,
        CMD_CUT      = 4'd7,
        CMD_PASTE    = 4'd8,
        CMD_READ     = 4'd9
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLAN,
        S_LOAD_A,
        S_RUN_A,
        S_LOAD_B,
        S_RUN_B,
        S_READ,
        S_COMMIT
    } state_t;

    typedef enum logic [1:0] {
        SRC_TEXT,
        SRC_CLIP,
        SRC_CHAR
    } src_t;

    typedef struct packed {
        src_t              src;
        logic              dst_clip;
        logic              down;
        logic [ADDR_W-1:0] src_a;
        logic [ADDR_W-1:0] dst_a;
        logic [LEN_W-1:0]  cnt;
    } move_t;

    typedef struct packed {
        logic accept;
        logic plan;
        logic load;
        logic phase_b;
        logic run;
        logic read;
        logic commit;
    } ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic count_zero;
        logic res_free;
    } stat_t;

endpackage

### rtl/core/tbce_if.sv
// ----------------------------------------------------------------------------
// tbce_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface tbce_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [tbce_pkg::CMD_W-1:0]   command;
    logic [tbce_pkg::CHAR_W-1:0]  character;
    logic [tbce_pkg::AMT_W-1:0]   amount;
    logic [tbce_pkg::IDX_W-1:0]   read_index;

    modport source (output valid, command, character, amount, read_index, input ready);
    modport sink   (input valid, command, character, amount, read_index, output ready);
endinterface

interface tbce_res_if;
    logic                         valid;
    logic                         ready;
    logic [tbce_pkg::STAT_W-1:0]  status;
    logic [tbce_pkg::LEN_W-1:0]   text_length;
    logic [tbce_pkg::LEN_W-1:0]   cursor_pos;
    logic [tbce_pkg::CLEN_W-1:0]  clip_length;
    logic [tbce_pkg::CHAR_W-1:0]  read_char;

    modport source (output valid, status, text_length, cursor_pos, clip_length, read_char,
                    input ready);
    modport sink   (input valid, status, text_length, cursor_pos, clip_length, read_char,
                    output ready);
endinterface

### rtl/core/tbce_ctrl.sv
// ----------------------------------------------------------------------------
// tbce_ctrl
// Sequencer: plans a command, runs up to two copy passes, then commits.
// ----------------------------------------------------------------------------
module tbce_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  tbce_pkg::stat_t      st,
    output tbce_pkg::ctrl_t      ctrl
);

    tbce_pkg::state_t state_reg;
    tbce_pkg::state_t state_next;
    logic             has_b;

    always_comb
    begin
        case (st.cmd)
            tbce_pkg::CMD_INSERT,
            tbce_pkg::CMD_PASTE,
            tbce_pkg::CMD_CUT: has_b = 1'b1;
            default:           has_b = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tbce_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tbce_pkg::S_IDLE:
                if (in_valid)
                    state_next = tbce_pkg::S_PLAN;
            tbce_pkg::S_PLAN:
                case (st.cmd)
                    tbce_pkg::CMD_INSERT:
                        state_next = st.full ? tbce_pkg::S_COMMIT : tbce_pkg::S_LOAD_A;
                    tbce_pkg::CMD_PASTE,
                    tbce_pkg::CMD_DELETE,
                    tbce_pkg::CMD_COPY,
                    tbce_pkg::CMD_CUT:
                        state_next = tbce_pkg::S_LOAD_A;
                    tbce_pkg::CMD_READ:
                        state_next = tbce_pkg::S_READ;
                    default:
                        state_next = tbce_pkg::S_COMMIT;
                endcase
            tbce_pkg::S_LOAD_A:
                state_next = tbce_pkg::S_RUN_A;
            tbce_pkg::S_RUN_A:
                if (st.count_zero)
                    state_next = has_b ? tbce_pkg::S_LOAD_B : tbce_pkg::S_COMMIT;
            tbce_pkg::S_LOAD_B:
                state_next = tbce_pkg::S_RUN_B;
            tbce_pkg::S_RUN_B:
                if (st.count_zero)
                    state_next = tbce_pkg::S_COMMIT;
            tbce_pkg::S_READ:
                state_next = tbce_pkg::S_COMMIT;
            tbce_pkg::S_COMMIT:
                if (st.res_free)
                    state_next = tbce_pkg::S_IDLE;
            default:
                state_next = tbce_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            tbce_pkg::S_IDLE:   ctrl.accept = 1'b1;
            tbce_pkg::S_PLAN:   ctrl.plan   = 1'b1;
            tbce_pkg::S_LOAD_A: ctrl.load   = 1'b1;
            tbce_pkg::S_RUN_A:  ctrl.run    = 1'b1;
            tbce_pkg::S_LOAD_B:
            begin
                ctrl.load    = 1'b1;
                ctrl.phase_b = 1'b1;
            end
            tbce_pkg::S_RUN_B:  ctrl.run    = 1'b1;
            tbce_pkg::S_READ:   ctrl.read   = 1'b1;
            tbce_pkg::S_COMMIT: ctrl.commit = st.res_free;
            default:            ctrl = '0;
        endcase
    end

endmodule

### rtl/core/tbce_dp.sv
// ----------------------------------------------------------------------------
// tbce_dp
// Text and clipboard stores, size registers, copy engine and result register.
// ----------------------------------------------------------------------------
module tbce_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbce_pkg::ctrl_t      ctrl,
    output tbce_pkg::stat_t      st,
    tbce_cmd_if.sink             cmd_in,
    tbce_res_if.source           res_out
);

    localparam int LW = tbce_pkg::LEN_W;
    localparam int AW = tbce_pkg::ADDR_W;
    localparam int CW = tbce_pkg::CLEN_W;

    logic [7:0] text_mem [tbce_pkg::TEXT_DEPTH];
    logic [7:0] clip_mem [tbce_pkg::CLIP_DEPTH];

    tbce_pkg::cmd_t              cmd_reg;
    logic [tbce_pkg::CHAR_W-1:0] char_reg;
    logic [tbce_pkg::AMT_W-1:0]  amount_reg;
    logic [tbce_pkg::IDX_W-1:0]  idx_reg;

    logic [LW-1:0] length_reg, length_next;
    logic [LW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] clip_len_reg, clip_len_next;

    logic [LW-1:0] n_reg, back_reg, k_reg;
    logic [CW-1:0] c_reg;
    logic          ctrunc_reg, ptrunc_reg;

    tbce_pkg::move_t mv_reg, mv_a, mv_b, mv_sel;

    logic                     wr_pend_reg;
    tbce_pkg::src_t           wr_src_reg;
    logic                     wr_clip_reg;
    logic [AW-1:0]            wr_addr_reg;
    logic [7:0]               text_q_reg, clip_q_reg, wr_data;

    logic                     res_valid_reg;
    logic [tbce_pkg::STAT_W-1:0] res_status_reg, status_next;
    logic [LW-1:0]            res_len_reg, res_cur_reg;
    logic [CW-1:0]            res_clip_reg;
    logic [7:0]               res_char_reg;

    logic [LW-1:0] after, n_cl, back_cl, room, k_cl, clip_ext;
    logic          in_range, text_re, clip_re, issue;
    logic [AW-1:0] text_ra;

    assign after    = length_reg - cursor_reg;
    assign n_cl     = (tbce_pkg::AMT_W'(after) < amount_reg) ? after : LW'(amount_reg);
    assign back_cl  = (tbce_pkg::AMT_W'(cursor_reg) < amount_reg) ? cursor_reg
                                                                  : LW'(amount_reg);
    assign room     = LW'(tbce_pkg::TEXT_DEPTH) - length_reg;
    assign clip_ext = LW'(clip_len_reg);
    assign k_cl     = (clip_ext > room) ? room : clip_ext;
    assign in_range = LW'(idx_reg) < length_reg;

    assign st.cmd        = cmd_reg;
    assign st.full       = (length_reg == LW'(tbce_pkg::TEXT_DEPTH));
    assign st.count_zero = (mv_reg.cnt == '0);
    assign st.res_free   = !res_valid_reg || res_out.ready;

    assign cmd_in.ready = ctrl.accept;

    always_ff @(posedge clk)
    begin
        if (ctrl.accept && cmd_in.valid)
        begin
            cmd_reg    <= tbce_pkg::cmd_t'(cmd_in.command);
            char_reg   <= cmd_in.character;
            amount_reg <= cmd_in.amount;
            idx_reg    <= cmd_in.read_index;
        end
        if (ctrl.plan)
        begin
            n_reg      <= n_cl;
            back_reg   <= back_cl;
            k_reg      <= k_cl;
            ptrunc_reg <= clip_ext > room;
            ctrunc_reg <= n_cl > LW'(tbce_pkg::CLIP_DEPTH);
            c_reg      <= (n_cl > LW'(tbce_pkg::CLIP_DEPTH)) ? CW'(tbce_pkg::CLIP_DEPTH)
                                                             : CW'(n_cl);
        end
    end

    // pass descriptors
    always_comb
    begin
        mv_a = '0;
        mv_b = '0;
        case (cmd_reg)
            tbce_pkg::CMD_INSERT:
            begin
                mv_a.src   = tbce_pkg::SRC_TEXT;
                mv_a.down  = 1'b1;
                mv_a.src_a = AW'(length_reg - LW'(1));
                mv_a.dst_a = AW'(length_reg);
                mv_a.cnt   = after;
                mv_b.src   = tbce_pkg::SRC_CHAR;
                mv_b.dst_a = AW'(cursor_reg);
                mv_b.cnt   = LW'(1);
            end
            tbce_pkg::CMD_PASTE:
            begin
                mv_a.src   = tbce_pkg::SRC_TEXT;
                mv_a.down  = 1'b1;
                mv_a.src_a = AW'(length_reg - LW'(1));
                mv_a.dst_a = AW'(length_reg - LW'(1) + k_reg);
                mv_a.cnt   = (k_reg == '0) ? '0 : after;
                mv_b.src   = tbce_pkg::SRC_CLIP;
                mv_b.dst_a = AW'(cursor_reg);
                mv_b.cnt   = k_reg;
            end
            tbce_pkg::CMD_DELETE:
            begin
                mv_a.src   = tbce_pkg::SRC_TEXT;
                mv_a.src_a = AW'(cursor_reg + n_reg);
                mv_a.dst_a = AW'(cursor_reg);
                mv_a.cnt   = after - n_reg;
            end
            tbce_pkg::CMD_COPY,
            tbce_pkg::CMD_CUT:
            begin
                mv_a.src      = tbce_pkg::SRC_TEXT;
                mv_a.dst_clip = 1'b1;
                mv_a.src_a    = AW'(cursor_reg);
                mv_a.cnt      = LW'(c_reg);
                mv_b.src      = tbce_pkg::SRC_TEXT;
                mv_b.src_a    = AW'(cursor_reg + n_reg);
                mv_b.dst_a    = AW'(cursor_reg);
                mv_b.cnt      = after - n_reg;
            end
            default:
            begin
                mv_a = '0;
                mv_b = '0;
            end
        endcase
        mv_sel = ctrl.phase_b ? mv_b : mv_a;
    end

    // copy engine: read one beat a cycle, write it in the cycle after
    assign issue = ctrl.run && (mv_reg.cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_pend_reg <= 1'b0;
        else
            wr_pend_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            mv_reg <= mv_sel;
        else if (issue)
        begin
            mv_reg.cnt   <= mv_reg.cnt - LW'(1);
            mv_reg.src_a <= mv_reg.down ? mv_reg.src_a - AW'(1) : mv_reg.src_a + AW'(1);
            mv_reg.dst_a <= mv_reg.down ? mv_reg.dst_a - AW'(1) : mv_reg.dst_a + AW'(1);
        end
        if (issue)
        begin
            wr_src_reg  <= mv_reg.src;
            wr_clip_reg <= mv_reg.dst_clip;
            wr_addr_reg <= mv_reg.dst_a;
        end
    end

    always_comb
    begin
        case (wr_src_reg)
            tbce_pkg::SRC_TEXT: wr_data = text_q_reg;
            tbce_pkg::SRC_CLIP: wr_data = clip_q_reg;
            default:            wr_data = char_reg;
        endcase
    end

    assign text_re = ctrl.read || (issue && mv_reg.src == tbce_pkg::SRC_TEXT);
    assign clip_re = issue && mv_reg.src == tbce_pkg::SRC_CLIP;
    assign text_ra = ctrl.read ? AW'(idx_reg) : mv_reg.src_a;

    always_ff @(posedge clk)
    begin
        if (wr_pend_reg && !wr_clip_reg)
            text_mem[wr_addr_reg[tbce_pkg::TEXT_AW-1:0]] <= wr_data;
        if (text_re)
            text_q_reg <= text_mem[text_ra[tbce_pkg::TEXT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_pend_reg && wr_clip_reg)
            clip_mem[wr_addr_reg[tbce_pkg::CLIP_AW-1:0]] <= wr_data;
        if (clip_re)
            clip_q_reg <= clip_mem[mv_reg.src_a[tbce_pkg::CLIP_AW-1:0]];
    end

    // commit
    always_comb
    begin
        length_next   = length_reg;
        cursor_next   = cursor_reg;
        clip_len_next = clip_len_reg;
        status_next   = tbce_pkg::STAT_OK;
        case (cmd_reg)
            tbce_pkg::CMD_INSERT:
                if (st.full)
                    status_next = tbce_pkg::STAT_FULL;
                else
                begin
                    length_next = length_reg + LW'(1);
                    cursor_next = cursor_reg + LW'(1);
                end
            tbce_pkg::CMD_START:    cursor_next = '0;
            tbce_pkg::CMD_END:      cursor_next = length_reg;
            tbce_pkg::CMD_FORWARD:  cursor_next = cursor_reg + n_reg;
            tbce_pkg::CMD_BACKWARD: cursor_next = cursor_reg - back_reg;
            tbce_pkg::CMD_DELETE:   length_next = length_reg - n_reg;
            tbce_pkg::CMD_COPY:
            begin
                clip_len_next = c_reg;
                status_next   = ctrunc_reg ? tbce_pkg::STAT_FULL : tbce_pkg::STAT_OK;
            end
            tbce_pkg::CMD_CUT:
            begin
                clip_len_next = c_reg;
                length_next   = length_reg - n_reg;
                status_next   = ctrunc_reg ? tbce_pkg::STAT_FULL : tbce_pkg::STAT_OK;
            end
            tbce_pkg::CMD_PASTE:
            begin
                length_next = length_reg + k_reg;
                cursor_next = cursor_reg + k_reg;
                status_next = ptrunc_reg ? tbce_pkg::STAT_FULL : tbce_pkg::STAT_OK;
            end
            tbce_pkg::CMD_READ:
                status_next = in_range ? tbce_pkg::STAT_OK : tbce_pkg::STAT_RANGE;
            default:
                status_next = tbce_pkg::STAT_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            cursor_reg    <= '0;
            clip_len_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.commit)
            begin
                length_reg    <= length_next;
                cursor_reg    <= cursor_next;
                clip_len_reg  <= clip_len_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            res_status_reg <= status_next;
            res_len_reg    <= length_next;
            res_cur_reg    <= cursor_next;
            res_clip_reg   <= clip_len_next;
            res_char_reg   <= (cmd_reg == tbce_pkg::CMD_READ && in_range) ? text_q_reg : '0;
        end
    end

    assign res_out.valid       = res_valid_reg;
    assign res_out.status      = res_status_reg;
    assign res_out.text_length = res_len_reg;
    assign res_out.cursor_pos  = res_cur_reg;
    assign res_out.clip_length = res_clip_reg;
    assign res_out.read_char   = res_char_reg;

endmodule

### rtl/core/text_buffer_cursor_editor.sv
// ----------------------------------------------------------------------------
// text_buffer_cursor_editor
// Bounded text store with cursor and clipboard, one command beat in,
// one result beat out.
//
//   channel   dir   beat
//   cmd_in    in    command, character, amount, read_index
//   res_out   out   status, text_length, cursor_pos, clip_length, read_char
//
// One command at a time. Moves and reads run no copy pass; insert, delete,
// copy, cut and paste shift or copy each character one by one through
// the store's single read and write port.
// No clearing pass after reset. A pending result beat is held in its own
// register; a new command is taken meanwhile and waits at commit.
// ----------------------------------------------------------------------------
module text_buffer_cursor_editor (
    input  logic        clk,
    input  logic        rst_n,
    tbce_cmd_if.sink    cmd_in,
    tbce_res_if.source  res_out
);

    tbce_pkg::ctrl_t ctrl;
    tbce_pkg::stat_t st;

    tbce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_in.valid),
        .st       (st),
        .ctrl     (ctrl)
    );

    tbce_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .st      (st),
        .cmd_in  (cmd_in),
        .res_out (res_out)
    );

endmodule
